// File: rtl/bed3_pkg.sv
// ----------------------------------------------------------------------------
// bed3_pkg: shared types and constants of the 3x3 binary erode/dilate block
// Payload structs, per-item control flags, register indexes and defaults.
// ----------------------------------------------------------------------------
package bed3_pkg;

    // Default size limits of the line buffer and the row counter.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 11'd480;

    localparam logic [7:0] FULL_PIXEL = 8'hFF;

    typedef struct packed {
        logic [7:0] pixel_in;
        logic       pad;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_last;
    } t_pix_out;

    // Classification that the front attaches to every beat.
    typedef struct packed {
        logic has_result;  // this beat retires one result pixel
        logic last;        // that result closes the frame
        logic interior;    // that result pixel is not on the border
    } t_item_ctl;

endpackage

// File: rtl/bed3_ram.sv
// ----------------------------------------------------------------------------
// bed3_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bed3_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/bed3_queue.sv
// ----------------------------------------------------------------------------
// bed3_queue: small register FIFO between front and back
// Holds classified beats so that either side can stall on its own.
// ----------------------------------------------------------------------------
module bed3_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = bed3_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slot [DEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic [PW-1:0]     n_wr_ptr;
    logic [PW-1:0]     n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

endmodule

// File: rtl/bed3_front.sv
// ----------------------------------------------------------------------------
// bed3_front: configuration registers, raster position and beat classification
// Tracks the column and row of the next beat and tags each beat with whether
// it retires a result, whether that result is interior and whether it is last.
// ----------------------------------------------------------------------------
module bed3_front #(
    parameter int MAX_WIDTH  = bed3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bed3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_write,
    input  logic [bed3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bed3_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_accept,
    input  bed3_pkg::t_pix_in                 i_pix,
    output logic                              o_mode,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_col,
    output logic [7:0]                        o_px,
    output bed3_pkg::t_item_ctl               o_ctl
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WV = $clog2(MAX_WIDTH + 1);
    localparam int HV = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);

    logic          r_mode;
    logic [WV-1:0] r_width;
    logic [HV-1:0] r_height;
    logic [AW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic [WV-1:0] width_sat;
    logic [HV-1:0] height_sat;
    logic [WV-1:0] col_ext;
    logic [WV-1:0] q_col;
    logic [RW-1:0] q_row;
    logic          has_result;
    logic          last;
    logic          interior;
    logic          row_end;

    // Zero counts as one; values above MAX_WIDTH or MAX_HEIGHT saturate.
    always_comb begin
        if (i_cfg_data == '0) begin
            width_sat = WV'(1);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            width_sat = WV'(MAX_WIDTH);
        end else begin
            width_sat = WV'(i_cfg_data);
        end
        if (i_cfg_data == '0) begin
            height_sat = HV'(1);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            height_sat = HV'(MAX_HEIGHT);
        end else begin
            height_sat = HV'(i_cfg_data);
        end
    end

    assign col_ext = WV'(r_col);

    // Position of the pixel whose result this beat retires.
    always_comb begin
        if (r_col != '0) begin
            q_col = col_ext - 1'b1;
            q_row = r_row - 1'b1;
        end else begin
            q_col = r_width - 1'b1;
            q_row = r_row - RW'(2);
        end
    end

    assign has_result = (r_row >= RW'(2)) || ((r_row == RW'(1)) && (r_col != '0));
    assign last       = (r_col == '0) && (r_row == RW'(r_height) + 1'b1);
    assign interior   = (q_row != '0) && ((RW'(q_row) + RW'(2)) <= RW'(r_height) + 1'b1)
                        && (q_row != RW'(r_height) - 1'b1)
                        && (q_col != '0) && ((q_col + 1'b1) < r_width);
    assign row_end    = (col_ext + 1'b1) >= r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= bed3_pkg::MODE_ERODE;
            r_width  <= WV'(bed3_pkg::RST_WIDTH > CFG_MAXW() ? CFG_MAXW() :
                            bed3_pkg::RST_WIDTH);
            r_height <= HV'(bed3_pkg::RST_HEIGHT > CFG_MAXH() ? CFG_MAXH() :
                            bed3_pkg::RST_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                bed3_pkg::CFG_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                bed3_pkg::CFG_WIDTH: begin
                    r_width <= width_sat;
                    r_col   <= '0;
                    r_row   <= '0;
                end
                bed3_pkg::CFG_HEIGHT: begin
                    r_height <= height_sat;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            if (last) begin
                r_col <= '0;
                r_row <= '0;
            end else if (row_end) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    function automatic logic [bed3_pkg::CFG_DATA_W-1:0] CFG_MAXW();
        return (MAX_WIDTH > 2047) ? 11'd2047 : bed3_pkg::CFG_DATA_W'(MAX_WIDTH);
    endfunction

    function automatic logic [bed3_pkg::CFG_DATA_W-1:0] CFG_MAXH();
        return (MAX_HEIGHT > 2047) ? 11'd2047 : bed3_pkg::CFG_DATA_W'(MAX_HEIGHT);
    endfunction

    assign o_mode = r_mode;
    assign o_col  = r_col;
    assign o_px   = i_pix.pad ? 8'd0 : i_pix.pixel_in;
    assign o_ctl  = '{has_result: has_result, last: last, interior: interior};

endmodule

// File: rtl/bed3_back.sv
// ----------------------------------------------------------------------------
// bed3_back: line buffer, 3x3 window and result stage
// Reads the line buffer for each beat, shifts the window, writes the buffer
// back and registers the result pixel in the output stage.
// ----------------------------------------------------------------------------
module bed3_back #(
    parameter int MAX_WIDTH = bed3_pkg::DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_mode,
    input  logic                         i_q_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_q_col,
    input  logic [7:0]                   i_q_px,
    input  bed3_pkg::t_item_ctl          i_q_ctl,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output bed3_pkg::t_pix_out           o_out_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    // Line buffer word: nonzero flag of row r-2 above the pixel of row r-1.
    logic                 r_b1_valid;
    logic [AW-1:0]        r_b1_col;
    logic [7:0]           r_b1_px;
    bed3_pkg::t_item_ctl  r_b1_ctl;
    logic                 r_byp;
    logic [8:0]           r_byp_data;
    logic [2:0]           r_win_top;
    logic [23:0]          r_win_mid;
    logic [2:0]           r_win_bot;
    logic                 r_out_valid;
    bed3_pkg::t_pix_out   r_out;

    logic [8:0]  ram_q;
    logic [8:0]  rd_word;
    logic [8:0]  wr_word;
    logic        b1_go;
    logic        pop;
    logic [2:0]  n_win_top;
    logic [23:0] n_win_mid;
    logic [2:0]  n_win_bot;
    logic [7:0]  center;
    logic [7:0]  left_px;
    logic [7:0]  right_px;
    logic        any_zero;
    logic        any_set;
    logic [7:0]  result;

    assign b1_go = r_b1_valid && (!r_b1_ctl.has_result || !r_out_valid || !i_out_stall);
    assign pop   = i_q_valid && (!r_b1_valid || b1_go);

    assign rd_word = r_byp ? r_byp_data : ram_q;
    assign wr_word = {rd_word[7:0] != 8'd0, r_b1_px};

    bed3_ram #(
        .DATA_W (9),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (b1_go),
        .i_wr_addr (r_b1_col),
        .i_wr_data (wr_word),
        .i_rd_en   (pop),
        .i_rd_addr (i_q_col),
        .o_rd_data (ram_q)
    );

    assign n_win_top = {r_win_top[1:0], rd_word[8]};
    assign n_win_mid = {r_win_mid[15:0], rd_word[7:0]};
    assign n_win_bot = {r_win_bot[1:0], r_b1_px != 8'd0};

    assign left_px  = n_win_mid[23:16];
    assign center   = n_win_mid[15:8];
    assign right_px = n_win_mid[7:0];

    assign any_zero = (n_win_top != 3'b111) || (n_win_bot != 3'b111)
                      || (left_px == 8'd0) || (right_px == 8'd0);
    assign any_set  = (n_win_top != 3'b000) || (n_win_bot != 3'b000)
                      || (left_px != 8'd0) || (right_px != 8'd0);

    always_comb begin
        result = center;
        if (r_b1_ctl.interior) begin
            if (i_mode == bed3_pkg::MODE_ERODE) begin
                if ((center != 8'd0) && any_zero) begin
                    result = 8'd0;
                end
            end else begin
                if ((center == 8'd0) && any_set) begin
                    result = bed3_pkg::FULL_PIXEL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_win_top   <= '0;
            r_win_mid   <= '0;
            r_win_bot   <= '0;
        end else begin
            if (pop) begin
                r_b1_valid <= 1'b1;
            end else if (b1_go) begin
                r_b1_valid <= 1'b0;
            end
            if (b1_go) begin
                r_win_top <= n_win_top;
                r_win_mid <= n_win_mid;
                r_win_bot <= n_win_bot;
            end
            if (b1_go && r_b1_ctl.has_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b1_col   <= i_q_col;
            r_b1_px    <= i_q_px;
            r_b1_ctl   <= i_q_ctl;
            // The write of the beat leaving now lands on the address being read.
            r_byp      <= b1_go && (i_q_col == r_b1_col);
            r_byp_data <= wr_word;
        end
        if (b1_go && r_b1_ctl.has_result) begin
            r_out.pixel_out  <= result;
            r_out.frame_last <= r_b1_ctl.last;
        end
    end

    assign o_q_pop     = pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/binary_erode_dilate_3x3_top.sv
// ----------------------------------------------------------------------------
// binary_erode_dilate_3x3_top: streaming 3x3 binary erosion / dilation
// Raster-order 8-bit pixel stream in, one morphology pass per frame out.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock and, in steady state while nothing
// stalls, returns one result beat per clock; the single-port-per-cycle line
// buffer RAM (one read and one write each clock) is what sets that rate. A
// beat entering the input channel passes through the queue and the window
// stage into the output register, but results trail the image by one row plus
// one pixel, so after every frame the host sends frame_width + 1 beats with
// pad set to flush the tail; the last result of the frame carries frame_last.
// Mode 0 erodes (an interior nonzero pixel with any zero 8-neighbour becomes
// 0), mode 1 dilates (an interior zero pixel with any nonzero neighbour
// becomes 255); border rows and columns pass through unchanged. Configuration
// writes are accepted at any time (ready is always high) but must only be
// issued while the block is idle; writing the width or the height restarts
// the frame position. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module binary_erode_dilate_3x3_top #(
    parameter int MAX_WIDTH  = bed3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bed3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bed3_pkg::t_pix_in               i_in_data,
    // Result output channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bed3_pkg::t_pix_out              o_out_data,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bed3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bed3_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CTL_W = $bits(bed3_pkg::t_item_ctl);
    localparam int QW    = AW + 8 + CTL_W;

    logic                 in_accept;
    logic                 cfg_write;
    logic                 mode;
    logic [AW-1:0]        front_col;
    logic [7:0]           front_px;
    bed3_pkg::t_item_ctl  front_ctl;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [QW-1:0]        q_head;
    logic [AW-1:0]        head_col;
    logic [7:0]           head_px;
    bed3_pkg::t_item_ctl  head_ctl;

    // The front only stalls when the queue to the back is full.
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    bed3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (cfg_write),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_pix       (i_in_data),
        .o_mode      (mode),
        .o_col       (front_col),
        .o_px        (front_px),
        .o_ctl       (front_ctl)
    );

    bed3_queue #(
        .DATA_W (QW),
        .DEPTH  (bed3_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  ({front_col, front_px, front_ctl}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    assign head_col = q_head[QW-1 -: AW];
    assign head_px  = q_head[CTL_W +: 8];
    assign head_ctl = bed3_pkg::t_item_ctl'(q_head[CTL_W-1:0]);

    bed3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (mode),
        .i_q_valid   (q_valid),
        .i_q_col     (head_col),
        .i_q_px      (head_px),
        .i_q_ctl     (head_ctl),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
